// ===== hdl/ptte_pkg.sv =====
// ----------------------------------------------------------------------------
// ptte_pkg
// Shared types, event codes and queue command format for the pointer to
// touch event translator.
// ----------------------------------------------------------------------------
package ptte_pkg;

  localparam int TYPE_W  = 5;
  localparam int CODE_W  = 10;
  localparam int VALUE_W = 32;
  localparam int ID_W    = 16;
  localparam int SEQ_W   = 3;

  // Tracking identifier wraps to 0 once it has reached this value
  localparam logic [ID_W-1:0] TRACK_ID_MAX = 16'hFFFF;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH_DEF = 4;

  // Event types
  localparam logic [TYPE_W-1:0] EVT_SYN = 5'd0;
  localparam logic [TYPE_W-1:0] EVT_KEY = 5'd1;
  localparam logic [TYPE_W-1:0] EVT_ABS = 5'd3;

  // Axis codes
  localparam logic [CODE_W-1:0] CODE_ABS_X     = 10'd0;
  localparam logic [CODE_W-1:0] CODE_ABS_Y     = 10'd1;
  localparam logic [CODE_W-1:0] CODE_MT_SLOT   = 10'd47;
  localparam logic [CODE_W-1:0] CODE_MT_POS_X  = 10'd53;
  localparam logic [CODE_W-1:0] CODE_MT_POS_Y  = 10'd54;
  localparam logic [CODE_W-1:0] CODE_MT_TRACK  = 10'd57;

  // Button and key codes
  localparam logic [CODE_W-1:0] CODE_BTN_LEFT   = 10'd272;
  localparam logic [CODE_W-1:0] CODE_BTN_RIGHT  = 10'd273;
  localparam logic [CODE_W-1:0] CODE_BTN_MIDDLE = 10'd274;
  localparam logic [CODE_W-1:0] CODE_BTN_TOUCH  = 10'd330;
  localparam logic [CODE_W-1:0] CODE_GEAR_DOWN  = 10'd336;
  localparam logic [CODE_W-1:0] CODE_GEAR_UP    = 10'd337;
  localparam logic [CODE_W-1:0] CODE_KEY_BACK   = 10'd158;
  localparam logic [CODE_W-1:0] CODE_KEY_MENU   = 10'd139;
  localparam logic [CODE_W-1:0] CODE_KEY_UP     = 10'd103;
  localparam logic [CODE_W-1:0] CODE_KEY_DOWN   = 10'd108;

  localparam logic [VALUE_W-1:0] VAL_LIFTED = 32'hFFFF_FFFF;

  // Command kinds queued by the front
  typedef enum logic [1:0] {
    OP_FRAME_DOWN,  // full 8-event touch frame
    OP_FRAME_UP,    // 4-event lift frame
    OP_KEY,         // key with value, then sync
    OP_TAP          // key 1, sync, key 0, sync
  } op_t;

  // Last sequence step of each command
  localparam logic [SEQ_W-1:0] LAST_FRAME_DOWN = 3'd7;
  localparam logic [SEQ_W-1:0] LAST_FRAME_UP   = 3'd3;
  localparam logic [SEQ_W-1:0] LAST_KEY        = 3'd1;
  localparam logic [SEQ_W-1:0] LAST_TAP        = 3'd3;

  typedef struct packed {
    op_t               op;
    logic [CODE_W-1:0]  key_code;
    logic [VALUE_W-1:0] val_a;    // key value or X position
    logic [VALUE_W-1:0] val_b;    // Y position
    logic [ID_W-1:0]    id;
  } cmd_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== hdl/ptte_if.sv =====
// ----------------------------------------------------------------------------
// ptte_if
// Valid/ready channels for pointer events in and touch events out.
// ----------------------------------------------------------------------------
interface ptte_in_if import ptte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         kind;
  logic [CODE_W-1:0]         event_code;
  logic signed [VALUE_W-1:0] event_value;

  modport source (output valid, kind, event_code, event_value, input ready);
  modport sink   (input valid, kind, event_code, event_value, output ready);
endinterface

interface ptte_out_if import ptte_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         out_type;
  logic [CODE_W-1:0]         out_code;
  logic signed [VALUE_W-1:0] out_value;
  logic                      last_of_run;

  modport source (output valid, out_type, out_code, out_value, last_of_run,
                  input ready);
  modport sink   (input valid, out_type, out_code, out_value, last_of_run,
                  output ready);
endinterface

// ===== hdl/ptte_front.sv =====
// ----------------------------------------------------------------------------
// ptte_front
// Accepts pointer events, keeps touch state and queues one command per item
// that produces events.
// ----------------------------------------------------------------------------
module ptte_front import ptte_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  ptte_in_if.sink      in_ch,
  input  logic         q_full,
  output logic         push,
  output cmd_t         push_cmd
);

  logic              touch_down_r, touch_down_nxt;
  logic [ID_W-1:0]   touch_id_r, touch_id_nxt;
  logic [VALUE_W-1:0] pos_x_r, pos_x_nxt;
  logic [VALUE_W-1:0] pos_y_r, pos_y_nxt;
  logic              accept;
  logic [VALUE_W-1:0] value_u;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;
  assign value_u     = VALUE_W'(in_ch.event_value);

  always_comb begin
    touch_down_nxt    = touch_down_r;
    touch_id_nxt      = touch_id_r;
    pos_x_nxt         = pos_x_r;
    pos_y_nxt         = pos_y_r;
    push              = 1'b0;
    push_cmd.op       = OP_KEY;
    push_cmd.key_code = in_ch.event_code;
    push_cmd.val_a    = value_u;
    push_cmd.val_b    = pos_y_r;
    push_cmd.id       = touch_id_r;
    if (accept) begin
      if (in_ch.kind == EVT_KEY) begin
        unique case (in_ch.event_code)
          CODE_BTN_LEFT: begin
            push = 1'b1;
            if (value_u != '0) begin
              touch_down_nxt = 1'b1;
              push_cmd.op    = OP_FRAME_DOWN;
              push_cmd.val_a = pos_x_r;
            end else begin
              touch_down_nxt = 1'b0;
              push_cmd.op    = OP_FRAME_UP;
              touch_id_nxt   = (touch_id_r >= TRACK_ID_MAX) ? '0 : touch_id_r + 1'b1;
            end
          end
          CODE_BTN_MIDDLE: begin
            push              = 1'b1;
            push_cmd.key_code = CODE_KEY_BACK;
          end
          CODE_BTN_RIGHT: begin
            push              = 1'b1;
            push_cmd.key_code = CODE_KEY_MENU;
          end
          CODE_GEAR_DOWN: begin
            push              = 1'b1;
            push_cmd.op       = OP_TAP;
            push_cmd.key_code = CODE_KEY_DOWN;
          end
          CODE_GEAR_UP: begin
            push              = 1'b1;
            push_cmd.op       = OP_TAP;
            push_cmd.key_code = CODE_KEY_UP;
          end
          default: ;
        endcase
      end else if (in_ch.kind == EVT_ABS) begin
        unique case (in_ch.event_code)
          CODE_ABS_X: begin
            pos_x_nxt      = value_u;
            push           = touch_down_r;
            push_cmd.op    = OP_FRAME_DOWN;
            push_cmd.val_a = value_u;
          end
          CODE_ABS_Y: begin
            pos_y_nxt      = value_u;
            push           = touch_down_r;
            push_cmd.op    = OP_FRAME_DOWN;
            push_cmd.val_a = pos_x_r;
            push_cmd.val_b = value_u;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      touch_down_r <= 1'b0;
      touch_id_r   <= '0;
      pos_x_r      <= '0;
      pos_y_r      <= '0;
    end else begin
      touch_down_r <= touch_down_nxt;
      touch_id_r   <= touch_id_nxt;
      pos_x_r      <= pos_x_nxt;
      pos_y_r      <= pos_y_nxt;
    end
  end

endmodule

// ===== hdl/ptte_queue.sv =====
// ----------------------------------------------------------------------------
// ptte_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module ptte_queue import ptte_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  output logic    full,
  input  logic    pop,
  output q_head_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign head.valid = (cnt_r != '0);
  assign head.cmd  = slot_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && head.valid;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (do_pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== hdl/ptte_back.sv =====
// ----------------------------------------------------------------------------
// ptte_back
// Sequencer that expands one queued command into its run of touch events,
// one event per cycle while out_ch is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module ptte_back import ptte_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  q_head_t   head,
  output logic      pop,
  ptte_out_if.source out_ch
);

  cmd_t               cmd_r;
  logic               cmd_vld_r;
  logic [SEQ_W-1:0]   seq_r;
  logic               out_vld_r;
  logic [TYPE_W-1:0]  type_r, ev_type;
  logic [CODE_W-1:0]  code_r, ev_code;
  logic [VALUE_W-1:0] value_r, ev_value;
  logic               last_r, ev_last;
  logic               gen_fire;
  logic [SEQ_W-1:0]   last_seq;

  always_comb begin
    unique case (cmd_r.op)
      OP_FRAME_DOWN: last_seq = LAST_FRAME_DOWN;
      OP_FRAME_UP:   last_seq = LAST_FRAME_UP;
      OP_KEY:        last_seq = LAST_KEY;
      OP_TAP:        last_seq = LAST_TAP;
      default:       last_seq = LAST_KEY;
    endcase
  end

  // Event for the current command and step
  always_comb begin
    ev_type  = EVT_SYN;
    ev_code  = '0;
    ev_value = '0;
    ev_last  = (seq_r == last_seq);
    unique case (cmd_r.op)
      OP_FRAME_DOWN: begin
        case (seq_r)
          3'd0: begin ev_type = EVT_ABS; ev_code = CODE_MT_SLOT; end
          3'd1: begin
            ev_type  = EVT_ABS;
            ev_code  = CODE_MT_TRACK;
            ev_value = VALUE_W'(cmd_r.id);
          end
          3'd2: begin ev_type = EVT_ABS; ev_code = CODE_MT_POS_X; ev_value = cmd_r.val_a; end
          3'd3: begin ev_type = EVT_ABS; ev_code = CODE_MT_POS_Y; ev_value = cmd_r.val_b; end
          3'd4: begin ev_type = EVT_KEY; ev_code = CODE_BTN_TOUCH; ev_value = 32'd1; end
          3'd5: begin ev_type = EVT_ABS; ev_code = CODE_ABS_X; ev_value = cmd_r.val_a; end
          3'd6: begin ev_type = EVT_ABS; ev_code = CODE_ABS_Y; ev_value = cmd_r.val_b; end
          default: ;
        endcase
      end
      OP_FRAME_UP: begin
        case (seq_r)
          3'd0: begin ev_type = EVT_ABS; ev_code = CODE_MT_SLOT; end
          3'd1: begin ev_type = EVT_ABS; ev_code = CODE_MT_TRACK; ev_value = VAL_LIFTED; end
          3'd2: begin ev_type = EVT_KEY; ev_code = CODE_BTN_TOUCH; end
          default: ;
        endcase
      end
      OP_KEY: begin
        if (seq_r == 3'd0) begin
          ev_type  = EVT_KEY;
          ev_code  = cmd_r.key_code;
          ev_value = cmd_r.val_a;
        end
      end
      OP_TAP: begin
        // even steps carry the key, odd steps the sync
        if (!seq_r[0]) begin
          ev_type  = EVT_KEY;
          ev_code  = cmd_r.key_code;
          ev_value = (seq_r == 3'd0) ? 32'd1 : 32'd0;
        end
      end
      default: ;
    endcase
  end

  assign gen_fire = cmd_vld_r && (!out_vld_r || out_ch.ready);
  assign pop      = head.valid && (!cmd_vld_r || (gen_fire && ev_last));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_vld_r <= 1'b0;
      seq_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (pop) begin
        cmd_vld_r <= 1'b1;
        seq_r     <= '0;
      end else if (gen_fire) begin
        cmd_vld_r <= !ev_last;
        seq_r     <= seq_r + 1'b1;
      end
      if (gen_fire)          out_vld_r <= 1'b1;
      else if (out_ch.ready) out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= head.cmd;
    if (gen_fire) begin
      type_r  <= ev_type;
      code_r  <= ev_code;
      value_r <= ev_value;
      last_r  <= ev_last;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.out_type    = type_r;
  assign out_ch.out_code    = code_r;
  assign out_ch.out_value   = value_r;
  assign out_ch.last_of_run = last_r;

endmodule

// ===== hdl/pointer_to_touch_event_translator.sv =====
// ----------------------------------------------------------------------------
// pointer_to_touch_event_translator
// Turns pointer events into a single-slot multitouch event stream.
// ----------------------------------------------------------------------------
// Each accepted pointer item (type, code, signed value) yields a run of zero
// to eight touch events: a left press or an X/Y move while touching gives an
// 8-event frame, a left release gives a 4-event lift run, middle/right
// buttons give key + sync (2), gear buttons give a key tap pair (4), and
// anything else gives nothing. The front takes one item per cycle while the
// command queue (QUEUE_DEPTH entries) has room; the back sequencer emits one
// event per cycle while out_ch is not stalled. Items that produce nothing
// are not queued. The out_ch last_of_run flag marks the final event of each
// run. No clearing pass after reset; the block is ready on the first cycle
// after rst_n goes high.
// ----------------------------------------------------------------------------
module pointer_to_touch_event_translator import ptte_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptte_in_if.sink    in_ch,
  ptte_out_if.source out_ch
);

  // front -> queue
  logic    push;
  cmd_t    push_cmd;
  logic    q_full;

  // queue -> back
  q_head_t head;
  logic    pop;

  // Front: decode, touch state (down flag, id, last X/Y), snapshot into cmd
  ptte_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  // Queue decouples input acceptance from event emission
  ptte_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head)
  );

  // Back: step through each command, one event per cycle while out_ch is not stalled
  ptte_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

// ===== hdl/ptte_checker.sv =====
// ----------------------------------------------------------------------------
// ptte_checker
// Port-level checks on the touch event output stream.
// ----------------------------------------------------------------------------
module ptte_checker import ptte_pkg::*; (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [TYPE_W-1:0]         out_type,
  input logic [CODE_W-1:0]         out_code,
  input logic signed [VALUE_W-1:0] out_value,
  input logic                      last_of_run
);

  // Stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_type) &&
      $stable(out_code) && $stable(out_value) && $stable(last_of_run))
    else $error("output item changed while stalled");

  // Nothing pending right after reset
  a_rst_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // Every run ends with a sync report
  a_last_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && last_of_run |-> out_type == EVT_SYN)
    else $error("run ends on a non-sync event");

  // Sync reports are code 0, value 0
  a_sync_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_type == EVT_SYN |-> out_code == '0 && out_value == '0)
    else $error("sync event with nonzero code or value");

  // A sync that is taken and not last is followed at once by more of the run
  a_sync_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_type == EVT_SYN && !last_of_run
      |=> out_valid)
    else $error("run broke off after an inner sync");

endmodule

bind pointer_to_touch_event_translator ptte_checker u_ptte_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_type    (out_ch.out_type),
  .out_code    (out_ch.out_code),
  .out_value   (out_ch.out_value),
  .last_of_run (out_ch.last_of_run)
);
